// ----- sv/sri_pkg.sv -----
package sri_pkg;

	localparam int COORD_BITS = 16;
	localparam int SIZE_BITS  = COORD_BITS - 1;
	// Differences of coordinates, including the far rectangle sides, fit in two extra bits.
	localparam int DIFF_BITS  = COORD_BITS + 2;
	localparam int PROD_BITS  = 2 * DIFF_BITS;

	// Bit positions of the per-edge flags in edge_hits.
	localparam int EDGE_LEFT   = 0;
	localparam int EDGE_RIGHT  = 1;
	localparam int EDGE_TOP    = 2;
	localparam int EDGE_BOTTOM = 3;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] seg_start_x;
		logic signed [COORD_BITS-1:0] seg_start_y;
		logic signed [COORD_BITS-1:0] seg_end_x;
		logic signed [COORD_BITS-1:0] seg_end_y;
		logic signed [COORD_BITS-1:0] rect_left;
		logic signed [COORD_BITS-1:0] rect_top;
		logic        [SIZE_BITS-1:0]  rect_w;
		logic        [SIZE_BITS-1:0]  rect_h;
	} seg_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] edge_hits;
	} res_t;

	typedef struct packed {
		logic signed [DIFF_BITS-1:0] dx;
		logic signed [DIFF_BITS-1:0] dy;
		logic signed [DIFF_BITS-1:0] ndy;
		logic signed [DIFF_BITS-1:0] lpx;
		logic signed [DIFF_BITS-1:0] rpx;
		logic signed [DIFF_BITS-1:0] dyt;
		logic signed [DIFF_BITS-1:0] dyb;
		logic signed [DIFF_BITS-1:0] w;
		logic signed [DIFF_BITS-1:0] h;
	} diff_t;

	typedef struct packed {
		logic signed [PROD_BITS-1:0] hdx;
		logic signed [PROD_BITS-1:0] hl;
		logic signed [PROD_BITS-1:0] hr;
		logic signed [PROD_BITS-1:0] wndy;
		logic signed [PROD_BITS-1:0] wt;
		logic signed [PROD_BITS-1:0] wb;
		logic signed [PROD_BITS-1:0] xt;
		logic signed [PROD_BITS-1:0] xb;
		logic signed [PROD_BITS-1:0] yl;
		logic signed [PROD_BITS-1:0] yr;
	} prod_t;

	typedef struct packed {
		logic signed [PROD_BITS-1:0] den_v;
		logic signed [PROD_BITS-1:0] den_h;
		logic signed [PROD_BITS-1:0] na_l;
		logic signed [PROD_BITS-1:0] na_r;
		logic signed [PROD_BITS-1:0] na_t;
		logic signed [PROD_BITS-1:0] na_b;
		logic signed [PROD_BITS-1:0] nb_lt;
		logic signed [PROD_BITS-1:0] nb_r;
		logic signed [PROD_BITS-1:0] nb_b;
	} sum_t;

endpackage

// ----- sv/sri_diff.sv -----
module sri_diff import sri_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld,
	input  seg_t  seg,
	output logic  vld_s1,
	output diff_t diff_s1
);

	logic signed [DIFF_BITS-1:0] px, py, qx, qy, l, t, w, h;
	diff_t d;

	always_comb begin
		px = DIFF_BITS'(seg.seg_start_x);
		py = DIFF_BITS'(seg.seg_start_y);
		qx = DIFF_BITS'(seg.seg_end_x);
		qy = DIFF_BITS'(seg.seg_end_y);
		l  = DIFF_BITS'(seg.rect_left);
		t  = DIFF_BITS'(seg.rect_top);
		w  = DIFF_BITS'(seg.rect_w);
		h  = DIFF_BITS'(seg.rect_h);
		d.dx  = qx - px;
		d.dy  = qy - py;
		d.ndy = py - qy;
		d.lpx = l - px;
		d.rpx = l + w - px;
		d.dyt = py - t;
		d.dyb = py - t - h;
		d.w   = w;
		d.h   = h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= d;
		end
	end

endmodule

// ----- sv/sri_mul.sv -----
module sri_mul import sri_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_s1,
	input  diff_t diff_s1,
	output logic  vld_s2,
	output prod_t prod_s2
);

	prod_t p;

	always_comb begin
		p.hdx  = diff_s1.h * diff_s1.dx;
		p.hl   = diff_s1.h * diff_s1.lpx;
		p.hr   = diff_s1.h * diff_s1.rpx;
		p.wndy = diff_s1.w * diff_s1.ndy;
		p.wt   = diff_s1.w * diff_s1.dyt;
		p.wb   = diff_s1.w * diff_s1.dyb;
		p.xt   = diff_s1.dx * diff_s1.dyt;
		p.xb   = diff_s1.dx * diff_s1.dyb;
		p.yl   = diff_s1.dy * diff_s1.lpx;
		p.yr   = diff_s1.dy * diff_s1.rpx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= p;
		end
	end

endmodule

// ----- sv/sri_sum.sv -----
module sri_sum import sri_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_s2,
	input  prod_t prod_s2,
	output logic  vld_s3,
	output sum_t  sum_s3
);

	sum_t s;

	// The left and top edges start at the same corner, so they share one numerator.
	always_comb begin
		s.den_v = prod_s2.hdx;
		s.den_h = prod_s2.wndy;
		s.na_l  = prod_s2.hl;
		s.na_r  = prod_s2.hr;
		s.na_t  = prod_s2.wt;
		s.na_b  = prod_s2.wb;
		s.nb_lt = prod_s2.xt + prod_s2.yl;
		s.nb_r  = prod_s2.xt + prod_s2.yr;
		s.nb_b  = prod_s2.xb + prod_s2.yl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= s;
		end
	end

endmodule

// ----- sv/sri_cmp.sv -----
module sri_cmp import sri_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_s3,
	input  sum_t sum_s3,
	output logic vld_s4,
	output res_t res_s4
);

	// Both ratios na/den and nb/den must lie in [0,1]; a zero denominator never hits.
	function automatic logic crosses(
		input logic signed [PROD_BITS-1:0] den,
		input logic signed [PROD_BITS-1:0] na,
		input logic signed [PROD_BITS-1:0] nb
	);
		logic pos_ok;
		logic neg_ok;
		pos_ok = (den > 0) && (na >= 0) && (na <= den) && (nb >= 0) && (nb <= den);
		neg_ok = (den < 0) && (na <= 0) && (na >= den) && (nb <= 0) && (nb >= den);
		return pos_ok || neg_ok;
	endfunction

	res_t r;

	always_comb begin
		r.edge_hits = '0;
		r.edge_hits[EDGE_LEFT]   = crosses(sum_s3.den_v, sum_s3.na_l, sum_s3.nb_lt);
		r.edge_hits[EDGE_RIGHT]  = crosses(sum_s3.den_v, sum_s3.na_r, sum_s3.nb_r);
		r.edge_hits[EDGE_TOP]    = crosses(sum_s3.den_h, sum_s3.na_t, sum_s3.nb_lt);
		r.edge_hits[EDGE_BOTTOM] = crosses(sum_s3.den_h, sum_s3.na_b, sum_s3.nb_b);
		r.hit = |r.edge_hits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= r;
		end
	end

endmodule

// ----- sv/segment_rectangle_intersection_core.sv -----
// Segment versus axis-aligned rectangle crossing test.
//
// Input channel seg_valid/seg_stall/seg carries one segment (start, end) and
// one rectangle (top-left corner, width, height). A transfer happens at a
// clock edge with seg_valid high and seg_stall low. The result channel
// res_valid/res_stall/res returns, for each input transfer and in order, the
// per-edge crossing flags (left, right, top, bottom) and their OR.
//
// Four register stages: coordinate differences, products, numerator sums,
// and the sign-aware range compares. An input transfer passes through them in
// order to res_valid, and one item is taken every cycle while the result side
// does not stall. The multiplier stage sets the depth of the critical path.
//
// When res_stall holds a result, each stage keeps moving as long as a bubble
// lies ahead of it, so the input keeps taking items until the pipeline is full;
// the held result does not change. Reset (arst_n low) empties all stages at
// once; no result is pending afterwards.
module segment_rectangle_intersection_core import sri_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic seg_valid,
	output logic seg_stall,
	input  seg_t seg,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	logic  vld_s1, vld_s2, vld_s3, vld_s4;
	logic  en1, en2, en3, en4;
	diff_t diff_s1;
	prod_t prod_s2;
	sum_t  sum_s3;

	// A stage loads when it is empty or its content moves on in the same cycle.
	assign en4 = !vld_s4 || !res_stall;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;

	assign seg_stall = !en1;
	assign res_valid = vld_s4;

	sri_diff u_diff (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en1),
		.vld     (seg_valid),
		.seg     (seg),
		.vld_s1  (vld_s1),
		.diff_s1 (diff_s1)
	);

	sri_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en2),
		.vld_s1  (vld_s1),
		.diff_s1 (diff_s1),
		.vld_s2  (vld_s2),
		.prod_s2 (prod_s2)
	);

	sri_sum u_sum (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en3),
		.vld_s2  (vld_s2),
		.prod_s2 (prod_s2),
		.vld_s3  (vld_s3),
		.sum_s3  (sum_s3)
	);

	sri_cmp u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en4),
		.vld_s3 (vld_s3),
		.sum_s3 (sum_s3),
		.vld_s4 (vld_s4),
		.res_s4 (res)
	);

endmodule

// ----- sv/sri_checker.sv -----
module sri_checker import sri_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic seg_valid,
	input logic seg_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	// A held result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	// A held result keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res))
		else $error("result changed while stalled");

	// The summary flag is the OR of the edge flags.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.hit == (res.edge_hits != 4'b0000)))
		else $error("hit does not match edge flags");

	// Without backpressure from the result side the input is never stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_stall |-> !seg_stall)
		else $error("input stalled without result backpressure");

	// An input transfer into an idle pipeline with a free result side reaches res_valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_stall && !res_stall && !res_valid ##1 !res_stall ##1 !res_stall
			##1 !res_stall |=> res_valid)
		else $error("result missing after pipeline latency");

endmodule

bind segment_rectangle_intersection_core sri_checker u_sri_checker (.*);
